### rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers for the circular byte FIFO with a
// decimal push operation.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Default number of byte slots in the store.
  localparam int unsigned DepthDefault = 256;

  // Capacity after reset, before clamping to the store depth.
  localparam int unsigned CapReset = 256;

  // ASCII code of the digit zero.
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_DEC  = 2'd1,
    OP_POP  = 2'd2,
    OP_LEN  = 2'd3
  } op_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_DONE
  } state_e;

  // Decimal digits of an 8-bit value.
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Splits a byte into its decimal digits. The tens digit uses a
  // multiply by the reciprocal of ten, exact for remainders below 1029.
  function automatic digits_t dec_digits(input logic [7:0] v);
    digits_t    d;
    logic [1:0] h;
    logic [7:0] r8;
    logic [6:0] r;
    logic [14:0] prod;
    logic [3:0] t;
    logic [6:0] tx10;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r8 = v - (8'(h) * 8'd100);
    r = r8[6:0];
    prod = 15'(r) * 15'd205;
    t = prod[14:11];
    tx10 = 7'(t) * 7'd10;
    d.hund = 4'(h);
    d.tens = t;
    d.ones = 4'(r - tx10);
    return d;
  endfunction

endpackage

### rtl/byte_ring_fifo_with_decimal_push.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_decimal_push
// Circular byte FIFO that overwrites its oldest byte when full, with a
// push operation that stores a byte value as ASCII decimal digits.
// ----------------------------------------------------------------------------
//   Requests enter on the input channel (in_valid_i / in_stall_o) with an
//   operation, a data byte and a burst end mark. Each yields one result on
//   the output channel (out_valid_o / out_stall_i): a status, a popped byte
//   and the fill level after the operation.
//   Push byte, pop and fill level requests go from idle to the done state,
//   which loads the result register; a new one is taken back in idle. A
//   decimal push writes one digit per cycle through the single write port
//   of the byte store, in the decimal state, before it reaches done.
//   A new request is taken while an earlier result waits in the output
//   register. A stalled receiver holds that result, and the block finishes
//   the next request and then stalls its input until the register drains.
//   Reset empties the FIFO and sets the capacity to 256 slots (or DEPTH if
//   smaller). A capacity write also empties it; zero acts as one and a value
//   above DEPTH as DEPTH. Stored bytes are read only after being written.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_decimal_push #(
  parameter int unsigned DEPTH = brf_pkg::DepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration port
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  // Request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_in_i,
  input  logic       burst_end_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] data_out_o,
  output logic [8:0] fill_level_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (AW > 9) ? AW : 9;
  localparam logic [8:0] CAP_RST =
    9'((brf_pkg::CapReset < DEPTH) ? brf_pkg::CapReset : DEPTH);

  // Pointer advance with wrap at the effective capacity.
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [8:0] cap);
    logic [PW-1:0] n;
    n = p + PW'(1);
    return (n >= PW'(cap)) ? '0 : n;
  endfunction

  brf_pkg::state_e state_q, state_d;

  logic [8:0]    cap_q, cap_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [PW-1:0] wptr_q, wptr_d;
  logic [8:0]    count_q, count_d;
  logic          burst_q, burst_d;

  logic [1:0]    res_status_q, res_status_d;
  logic          res_pop_q, res_pop_d;

  logic [3:0]    dig_q [3];
  logic [1:0]    dig_idx_q;
  logic          dig_over_q, dig_over_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q;
  logic [7:0]    data_q;
  logic [8:0]    fill_q;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_q;
  logic          put_en, rd_en;
  logic [7:0]    put_data;

  logic          in_acc, out_free, out_load, put_full;
  brf_pkg::op_e  op;
  brf_pkg::digits_t dig_in;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign op       = brf_pkg::op_e'(op_i);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign out_load = (state_q == brf_pkg::S_DONE) && out_free;
  assign put_full = count_q >= cap_q;
  assign dig_in   = brf_pkg::dec_digits(data_in_i);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      brf_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (op == brf_pkg::OP_DEC) ? brf_pkg::S_DEC : brf_pkg::S_DONE;
        end
      end
      brf_pkg::S_DEC: begin
        if (dig_idx_q == 2'd2) begin
          state_d = brf_pkg::S_DONE;
        end
      end
      brf_pkg::S_DONE: begin
        if (out_free) begin
          state_d = brf_pkg::S_IDLE;
        end
      end
      default: state_d = brf_pkg::S_IDLE;
    endcase
  end

  // Store accesses, pointer updates and result status per state.
  always_comb begin
    put_en       = 1'b0;
    put_data     = data_in_i;
    rd_en        = 1'b0;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    count_d      = count_q;
    burst_d      = burst_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_pop_d    = res_pop_q;
    dig_over_d   = dig_over_q;

    case (state_q)
      brf_pkg::S_IDLE: begin
        if (in_acc) begin
          res_status_d = brf_pkg::ST_OK;
          res_pop_d    = 1'b0;
          case (op)
            brf_pkg::OP_PUSH: begin
              put_en = 1'b1;
              if (put_full || (burst_end_i && burst_q)) begin
                res_status_d = brf_pkg::ST_OVER;
              end
              burst_d = ~burst_end_i & (burst_q | put_full);
            end
            brf_pkg::OP_DEC: begin
              dig_over_d = 1'b0;
            end
            brf_pkg::OP_POP: begin
              if (count_q == 9'd0) begin
                res_status_d = brf_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                res_pop_d = 1'b1;
                rptr_d    = adv(rptr_q, cap_q);
                count_d   = count_q - 9'd1;
              end
            end
            default: ;
          endcase
        end
      end
      brf_pkg::S_DEC: begin
        put_en     = 1'b1;
        put_data   = brf_pkg::ASCII_ZERO + 8'(dig_q[dig_idx_q]);
        dig_over_d = dig_over_q | put_full;
        if (dig_idx_q == 2'd2) begin
          res_status_d = (dig_over_q | put_full) ? brf_pkg::ST_OVER : brf_pkg::ST_OK;
        end
      end
      default: ;
    endcase

    // A write advances the write pointer and drops the oldest byte if full.
    if (put_en) begin
      wptr_d = adv(wptr_q, cap_q);
      if (put_full) begin
        rptr_d = adv(rptr_q, cap_q);
      end else begin
        count_d = count_q + 9'd1;
      end
    end

    // A capacity write clamps the value and empties the FIFO.
    if (cfg_we_i) begin
      if (cfg_wdata_i == 9'd0) begin
        cap_d = 9'd1;
      end else if (32'(cfg_wdata_i) > DEPTH) begin
        cap_d = 9'(DEPTH);
      end else begin
        cap_d = cfg_wdata_i;
      end
      rptr_d  = '0;
      wptr_d  = '0;
      count_d = '0;
      burst_d = 1'b0;
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brf_pkg::S_IDLE;
      cap_q       <= CAP_RST;
      rptr_q      <= '0;
      wptr_q      <= '0;
      count_q     <= '0;
      burst_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      count_q     <= count_d;
      burst_q     <= burst_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result and digit registers.
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_pop_q    <= res_pop_d;
    dig_over_q   <= dig_over_d;
    if (in_acc && (op == brf_pkg::OP_DEC)) begin
      dig_q[0] <= dig_in.hund;
      dig_q[1] <= dig_in.tens;
      dig_q[2] <= dig_in.ones;
      if (data_in_i > 8'd99) begin
        dig_idx_q <= 2'd0;
      end else if (data_in_i > 8'd9) begin
        dig_idx_q <= 2'd1;
      end else begin
        dig_idx_q <= 2'd2;
      end
    end else if (state_q == brf_pkg::S_DEC) begin
      dig_idx_q <= dig_idx_q + 2'd1;
    end
    if (out_load) begin
      status_q <= res_status_q;
      data_q   <= res_pop_q ? rd_q : 8'd0;
      fill_q   <= count_q;
    end
  end

  // Byte store with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      mem_q[wptr_q[AW-1:0]] <= put_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rptr_q[AW-1:0]];
    end
  end

  assign in_stall_o   = (state_q != brf_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_out_o   = data_q;
  assign fill_level_o = fill_q;

  // The fill level never exceeds the capacity in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("fill level above capacity");

  // Both pointers stay inside the slots in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rptr_q < PW'(cap_q)) && (wptr_q < PW'(cap_q)))
    else $error("pointer outside capacity");

  // A byte push into a FIFO that is not full grows the fill level by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == brf_pkg::OP_PUSH) && !put_full && !cfg_we_i)
    |=> (count_q == $past(count_q) + 9'd1))
    else $error("push did not grow fill level");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular byte FIFO with decimal push. Requests
// are driven from a queue with random gaps and checked against an in-bench
// prediction of the FIFO contents. The bench walks through several capacity
// settings and holds off the result side for a long stretch at least once.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount = brf_pkg::DepthDefault;

  // One request as offered on the input channel.
  typedef struct {
    brf_pkg::op_e op;
    logic [7:0]   data;
    logic         last;
  } request_t;

  // One result as seen on the output channel.
  typedef struct {
    brf_pkg::status_e status;
    logic [7:0]       data;
    logic [8:0]       fill;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] op_i = brf_pkg::OP_LEN;
  logic [7:0] data_in_i = '0;
  logic       burst_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] data_out_o;
  logic [8:0] fill_level_o;

  request_t    pending_requests[$];
  result_t     expected_results[$];
  request_t    offered_request;
  int unsigned mismatch_count = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_cycles = 0;
  bit          tx_no_gaps = 1'b0;
  bit          rx_no_gaps = 1'b0;

  // Predicted FIFO state.
  logic [7:0]  fifo_bytes[SlotCount];
  int unsigned rd_slot = 0;
  int unsigned wr_slot = 0;
  int unsigned held = 0;
  bit          burst_overwrote = 1'b0;
  logic [8:0]  capacity_reg = 9'd256;

  byte_ring_fifo_with_decimal_push dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .burst_end_i (burst_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .fill_level_o(fill_level_o)
  );

  always #2 clk_i = ~clk_i;

  // Capacity in use: zero acts as one, anything above the store depth as the depth.
  function automatic int unsigned slots_in_use();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > SlotCount) return SlotCount;
    return capacity_reg;
  endfunction

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= slots_in_use()) ? 0 : p + 1;
  endfunction

  // Writes one byte and tells whether the oldest byte was overwritten.
  function automatic bit store_byte(input logic [7:0] b);
    bit overwrote;
    overwrote = 1'b0;
    fifo_bytes[wr_slot] = b;
    wr_slot = next_slot(wr_slot);
    if (held < slots_in_use()) begin
      held++;
    end else begin
      rd_slot = next_slot(rd_slot);
      overwrote = 1'b1;
    end
    return overwrote;
  endfunction

  // Applies one request to the predicted FIFO and returns its result.
  function automatic result_t predict_request(input request_t req);
    result_t     res;
    bit          over;
    int unsigned v;
    res.status = brf_pkg::ST_OK;
    res.data = '0;
    over = 1'b0;
    v = req.data;
    case (req.op)
      brf_pkg::OP_PUSH: begin
        over = store_byte(req.data);
        if (over) burst_overwrote = 1'b1;
        if (over || (req.last && burst_overwrote)) res.status = brf_pkg::ST_OVER;
        if (req.last) burst_overwrote = 1'b0;
      end
      brf_pkg::OP_DEC: begin
        // Digits go in most significant first, without leading zeros.
        if (v > 99) over |= store_byte(brf_pkg::ASCII_ZERO + 8'(v / 100));
        if (v > 9) over |= store_byte(brf_pkg::ASCII_ZERO + 8'((v % 100) / 10));
        over |= store_byte(brf_pkg::ASCII_ZERO + 8'(v % 10));
        if (over) res.status = brf_pkg::ST_OVER;
      end
      brf_pkg::OP_POP: begin
        if (held == 0) begin
          res.status = brf_pkg::ST_EMPTY;
        end else begin
          res.data = fifo_bytes[rd_slot];
          rd_slot = next_slot(rd_slot);
          held--;
        end
      end
      default: begin
      end
    endcase
    res.fill = 9'(held);
    return res;
  endfunction

  function automatic int unsigned draw_gap(input bit no_gaps);
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_request(input brf_pkg::op_e op, input logic [7:0] data,
                             input logic last);
    request_t req;
    req.op = op;
    req.data = data;
    req.last = last;
    pending_requests.push_back(req);
  endtask

  // Random requests, mostly well-formed push bursts and pop runs with random
  // content, the rest decimal pushes and noise with every field random.
  task automatic add_random_requests(input int unsigned count, input int unsigned pop_pct);
    int unsigned added;
    int unsigned r;
    int unsigned len;
    logic [7:0]  v;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        len = $urandom_range(1, 4);
        repeat (len) add_request(brf_pkg::OP_POP, 8'($urandom), 1'($urandom));
      end else if (r < pop_pct + 10) begin
        len = 1;
        add_request(brf_pkg::op_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end else if (r < pop_pct + 30) begin
        len = 1;
        case ($urandom_range(0, 2))
          0: v = 8'($urandom_range(0, 9));
          1: v = 8'($urandom_range(10, 99));
          default: v = 8'($urandom);
        endcase
        add_request(brf_pkg::OP_DEC, v, 1'($urandom));
      end else begin
        len = $urandom_range(1, 5);
        for (int unsigned i = 1; i <= len; i++)
          add_request(brf_pkg::OP_PUSH, 8'($urandom), i == len);
      end
      added += len;
    end
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // Writing the capacity empties the FIFO.
    capacity_reg = value;
    rd_slot = 0;
    wr_slot = 0;
    held = 0;
    burst_overwrote = 1'b0;
    @(posedge clk_i);
  endtask

  // Request driver: offers queued requests with random gaps and predicts
  // the result of each request at the edge where it is taken.
  always @(posedge clk_i) begin : drive_requests
    bit load;
    load = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      expected_results.push_back(predict_request(offered_request));
      tx_wait = draw_gap(tx_no_gaps);
      load = (tx_wait == 0) && (pending_requests.size() != 0);
      in_valid_i <= load;
    end else if (!in_valid_i) begin
      if (tx_wait != 0) tx_wait--;
      else load = pending_requests.size() != 0;
      in_valid_i <= load;
    end
    if (load) begin
      offered_request = pending_requests.pop_front();
      op_i <= offered_request.op;
      data_in_i <= offered_request.data;
      burst_end_i <= offered_request.last;
    end
  end

  // Long hold-off of the result side, counted down here.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // Result monitor: compares each taken result with the oldest prediction
  // and stalls the output channel at random.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d data %0d fill %0d",
                                  status_o, data_out_o, fill_level_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (data_out_o !== want.data)
          report_mismatch($sformatf("data_out %0d, expected %0d", data_out_o, want.data));
        if (fill_level_o !== want.fill)
          report_mismatch($sformatf("fill_level %0d, expected %0d", fill_level_o, want.fill));
      end
      rx_wait = draw_gap(rx_no_gaps);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= (hold_cycles != 0) || (rx_wait != 0);
  end

  // Stimulus sequence.
  initial begin
    logic [8:0] caps[9];
    caps = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd13, 9'd256, 9'd511, 9'd257,
             9'($urandom_range(3, 255))};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed requests at the reset capacity: empty pop, field extremes and
    // decimal values of every digit count.
    add_request(brf_pkg::OP_POP, 8'h00, 1'b0);
    add_request(brf_pkg::OP_LEN, 8'hFF, 1'b1);
    add_request(brf_pkg::OP_PUSH, 8'h00, 1'b0);
    add_request(brf_pkg::OP_PUSH, 8'hFF, 1'b1);
    add_request(brf_pkg::OP_DEC, 8'd0, 1'b0);
    add_request(brf_pkg::OP_DEC, 8'd9, 1'b1);
    add_request(brf_pkg::OP_DEC, 8'd10, 1'b0);
    add_request(brf_pkg::OP_DEC, 8'd99, 1'b0);
    add_request(brf_pkg::OP_DEC, 8'd100, 1'b0);
    add_request(brf_pkg::OP_DEC, 8'd255, 1'b0);
    add_request(brf_pkg::OP_POP, 8'h00, 1'b0);
    add_request(brf_pkg::OP_LEN, 8'h00, 1'b0);

    // Directed overflow cases with three slots: an overwrite inside a burst
    // that is flagged again on the burst's last byte, and a decimal push that
    // overwrites all its digits.
    write_capacity(9'd3);
    add_request(brf_pkg::OP_PUSH, 8'h11, 1'b0);
    add_request(brf_pkg::OP_PUSH, 8'h22, 1'b0);
    add_request(brf_pkg::OP_PUSH, 8'h33, 1'b0);
    add_request(brf_pkg::OP_PUSH, 8'h44, 1'b0);
    add_request(brf_pkg::OP_POP, 8'h00, 1'b0);
    add_request(brf_pkg::OP_PUSH, 8'h55, 1'b1);
    add_request(brf_pkg::OP_DEC, 8'd255, 1'b1);
    repeat (4) add_request(brf_pkg::OP_POP, 8'h00, 1'b0);

    // Random phases over the capacity settings.
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      tx_no_gaps = (i == 3);
      rx_no_gaps = (i == 3) || (i == 1);
      if (i == 4) begin
        // Result side holds off while the sender keeps offering requests.
        tx_no_gaps = 1'b1;
        hold_cycles <= 300;
      end
      if (i == 6) add_random_requests(400, 5);
      else add_random_requests(130, 30);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
